// ===== rtl/vgls_pkg.sv =====
// Package for the voxel gradient / Laplacian stencil core.
// Holds default sizes, status and operation codes, and the queue entry type.
// No dependencies.
package vgls_pkg;

    localparam int DEF_MAX_X       = 64;
    localparam int DEF_MAX_Y       = 64;
    localparam int DEF_MAX_Z       = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;
    localparam int RESP_W = 22;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MODE   = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_WRITTEN   = 2'd0;
    localparam logic [1:0] ST_WRITE_OOR = 2'd1;
    localparam logic [1:0] ST_COMPUTED  = 2'd2;
    localparam logic [1:0] ST_SKIPPED   = 2'd3;

    typedef struct packed {
        logic             op;
        logic             in_range;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [23:0]      sample;
        logic             mask;
    } vgls_cmd_t;

endpackage

// ===== rtl/vgls_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module vgls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/vgls_front.sv =====
// Front end: accepts transactions, checks range and queues commands.
// Depends on vgls_pkg.
module vgls_front #(
    parameter int MAX_X = vgls_pkg::DEF_MAX_X,
    parameter int MAX_Y = vgls_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vgls_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgls_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [vgls_pkg::POS_W-1:0]        pos_x,
    input  logic [vgls_pkg::POS_W-1:0]        pos_y,
    input  logic [vgls_pkg::POS_W-1:0]        pos_z,
    input  logic signed [SAMPLE_BITS-1:0]     intensity,
    input  logic                              in_mask,
    input  logic [vgls_pkg::SIZE_W-1:0]       ex,
    input  logic [vgls_pkg::SIZE_W-1:0]       ey,
    input  logic [vgls_pkg::SIZE_W-1:0]       ez,
    output logic                              q_valid,
    input  logic                              q_take,
    output vgls_pkg::vgls_cmd_t               q_cmd
);
    import vgls_pkg::*;

    vgls_cmd_t q_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    vgls_cmd_t cmd;
    logic      push;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = operation;
        cmd.in_range = ({1'b0, pos_x} < ex) && ({1'b0, pos_y} < ey) &&
                       ({1'b0, pos_z} < ez);
        cmd.x        = pos_x;
        cmd.y        = pos_y;
        cmd.z        = pos_z;
        cmd.sample   = 24'(signed'(intensity));
        cmd.mask     = in_mask;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_take);
        end
    end
endmodule

// ===== rtl/vgls_back.sv =====
// Back end: performs writes and stencil queries against the voxel RAM.
// Depends on vgls_pkg and vgls_ram.
module vgls_back #(
    parameter int MAX_X = vgls_pkg::DEF_MAX_X,
    parameter int MAX_Y = vgls_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vgls_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgls_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_take,
    input  vgls_pkg::vgls_cmd_t               q_cmd,
    input  logic [vgls_pkg::SIZE_W-1:0]       ex,
    input  logic [vgls_pkg::SIZE_W-1:0]       ey,
    input  logic [vgls_pkg::SIZE_W-1:0]       ez,
    input  logic                              mode,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [vgls_pkg::RESP_W-1:0] response
);
    import vgls_pkg::*;

    localparam int XW = ($clog2(MAX_X) < POS_W) ? $clog2(MAX_X) : POS_W;
    localparam int YW = ($clog2(MAX_Y) < POS_W) ? $clog2(MAX_Y) : POS_W;
    localparam int ZW = ($clog2(MAX_Z) < POS_W) ? $clog2(MAX_Z) : POS_W;
    localparam int AW = XW + YW + ZW;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int DEPTH = 1 << AW;
    localparam int SQ_W = 2 * SAMPLE_BITS + 4;
    localparam int RAD_W = SQ_W + 8;
    localparam int RAD_W2 = RAD_W + (RAD_W % 2);
    localparam int SQ_STEPS = RAD_W2 / 2;
    localparam int SW = SAMPLE_BITS + 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_CAP   = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0] state_reg, state_next;
    vgls_cmd_t  cmd_reg;
    logic [2:0] tap_reg;
    logic [2:0] cnt_reg;
    logic       oob_reg [7];
    logic signed [SAMPLE_BITS-1:0] nb_reg [7];
    logic signed [SAMPLE_BITS+1:0] d_reg [3];
    logic [1:0] sq_idx_reg;
    logic [SQ_W-1:0] sum_reg;
    logic [RAD_W2-1:0] rem_reg;
    logic [RAD_W2-1:0] bit_reg;
    logic [RAD_W2-1:0] res_reg;
    logic [$clog2(SQ_STEPS+1)-1:0] step_reg;
    logic [1:0] st_reg;
    logic [RESP_W-1:0] resp_reg;
    logic       ov_reg;
    logic       cmask_reg;

    logic we;
    logic [AW-1:0] addr;
    logic [DW-1:0] rdata;
    logic signed [POS_W+1:0] tx, ty, tz;
    logic t_oob;
    logic [RAD_W2+1:0] trial;
    logic signed [SW-1:0] lap;
    logic signed [2*SAMPLE_BITS+3:0] prod;

    vgls_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata({cmd_reg.mask, cmd_reg.sample[SAMPLE_BITS-1:0]}),
        .rdata(rdata)
    );

    // Tap order: centre, west, east, north, south, front, back.
    always_comb
    begin
        tx = signed'({2'b00, cmd_reg.x});
        ty = signed'({2'b00, cmd_reg.y});
        tz = signed'({2'b00, cmd_reg.z});
        case (tap_reg)
            3'd1: tx = tx - 8'sd1;
            3'd2: tx = tx + 8'sd1;
            3'd3: ty = ty - 8'sd1;
            3'd4: ty = ty + 8'sd1;
            3'd5: tz = tz - 8'sd1;
            3'd6: tz = tz + 8'sd1;
            default: ;
        endcase
        t_oob = tx < 0 || ty < 0 || tz < 0 || tx >= signed'({1'b0, ex}) ||
                ty >= signed'({1'b0, ey}) || tz >= signed'({1'b0, ez});
        addr = {tz[ZW-1:0], ty[YW-1:0], tx[XW-1:0]};
    end

    assign we = (state_reg == S_READ) && (cmd_reg.op == OP_WRITE) && cmd_reg.in_range;
    assign q_take = (state_reg == S_IDLE) && q_valid;

    assign prod = d_reg[sq_idx_reg] * d_reg[sq_idx_reg];
    assign trial = {2'b00, rem_reg} - {2'b00, bit_reg} - {2'b00, res_reg};
    assign lap = SW'(6) * SW'(nb_reg[0]) - (SW'(nb_reg[1]) + SW'(nb_reg[2]) + SW'(nb_reg[3])
                 + SW'(nb_reg[4]) + SW'(nb_reg[5]) + SW'(nb_reg[6]));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_READ;
            S_READ:
            begin
                if (cmd_reg.op == OP_WRITE || !cmd_reg.in_range)
                    state_next = S_OUT;
                else if (tap_reg == 3'd6)
                    state_next = S_WAIT;
            end
            S_WAIT:  state_next = S_CAP;
            S_CAP:   state_next = (!cmask_reg) ? S_OUT : S_DIFF;
            S_DIFF:  state_next = mode ? S_OUT : S_SQ;
            S_SQ:    if (sq_idx_reg == 2'd3) state_next = S_SQRT;
            S_SQRT:  if (step_reg == '0) state_next = S_OUT;
            S_OUT:   if (!ov_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == S_READ)
        begin
            oob_reg[tap_reg] <= t_oob;
        end
        if ((state_reg == S_READ && tap_reg != 3'd0) || state_reg == S_WAIT)
        begin
            nb_reg[cnt_reg] <= rdata[SAMPLE_BITS-1:0];
            if (cnt_reg == 3'd0)
                cmask_reg <= rdata[SAMPLE_BITS];
        end
        if (state_reg == S_CAP)
        begin
            nb_reg[0] <= nb_reg[0];
            for (int i = 1; i < 7; i++)
            begin
                if (oob_reg[i])
                    nb_reg[i] <= nb_reg[0];
            end
        end
        if (state_reg == S_DIFF)
        begin
            d_reg[0] <= (SAMPLE_BITS+2)'(nb_reg[1]) - (SAMPLE_BITS+2)'(nb_reg[2]);
            d_reg[1] <= (SAMPLE_BITS+2)'(nb_reg[3]) - (SAMPLE_BITS+2)'(nb_reg[4]);
            d_reg[2] <= (SAMPLE_BITS+2)'(nb_reg[5]) - (SAMPLE_BITS+2)'(nb_reg[6]);
            sum_reg  <= '0;
        end
        if (state_reg == S_SQ)
        begin
            if (sq_idx_reg != 2'd3)
                sum_reg <= sum_reg + SQ_W'(unsigned'(prod));
            rem_reg <= RAD_W2'({sum_reg, 8'h00});
            bit_reg <= {2'b01, {(RAD_W2-2){1'b0}}};
            res_reg <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            if (!trial[RAD_W2+1])
            begin
                rem_reg <= trial[RAD_W2-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tap_reg    <= 3'd0;
            cnt_reg    <= 3'd0;
            sq_idx_reg <= 2'd0;
            step_reg   <= '0;
            ov_reg     <= 1'b0;
            st_reg     <= ST_WRITTEN;
            resp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                tap_reg <= 3'd0;
                cnt_reg <= 3'd0;
            end
            if (state_reg == S_READ)
            begin
                tap_reg <= tap_reg + 3'd1;
                if (tap_reg != 3'd0)
                    cnt_reg <= cnt_reg + 3'd1;
            end
            if (state_reg == S_DIFF)
                sq_idx_reg <= 2'd0;
            if (state_reg == S_SQ)
            begin
                sq_idx_reg <= sq_idx_reg + 2'd1;
                step_reg   <= ($clog2(SQ_STEPS+1))'(SQ_STEPS);
            end
            if (state_reg == S_SQRT)
                step_reg <= step_reg - 1'b1;
            if (out_valid && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg != S_OUT && state_next == S_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
                resp_reg <= '0;
                if (cmd_reg.op == OP_WRITE)
                    st_reg <= cmd_reg.in_range ? ST_WRITTEN : ST_WRITE_OOR;
                else if (!cmd_reg.in_range || (state_reg == S_CAP && !cmask_reg))
                    st_reg <= ST_SKIPPED;
                else
                begin
                    st_reg <= ST_COMPUTED;
                    if (state_reg == S_DIFF)
                        resp_reg <= RESP_W'(lap);
                    else
                        resp_reg <= RESP_W'(res_reg);
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign response  = signed'(resp_reg);
endmodule

// ===== rtl/voxel_gradient_laplacian_stencil_core.sv =====
// Voxel stencil core, top level: configuration registers, front end and back end.
// Depends on vgls_pkg, vgls_front and vgls_back.
// A write transaction passes through the back end's read and output states; a query reads the centre
// and six neighbours one per cycle from the single voxel RAM port, then in Laplacian mode computes
// the result directly, or in gradient mode squares the differences and takes a square root that
// resolves one result bit per cycle. An out-of-range query skips the reads, and a masked-off one
// stops after reading the stencil. Results leave through an output register that holds the back
// end while it is stalled; the front queue holds two transactions.
module voxel_gradient_laplacian_stencil_core #(
    parameter int MAX_X = vgls_pkg::DEF_MAX_X,
    parameter int MAX_Y = vgls_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vgls_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgls_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vgls_pkg::IDX_W-1:0]          cfg_index,
    input  logic [vgls_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [vgls_pkg::POS_W-1:0]          pos_x,
    input  logic [vgls_pkg::POS_W-1:0]          pos_y,
    input  logic [vgls_pkg::POS_W-1:0]          pos_z,
    input  logic signed [SAMPLE_BITS-1:0]       intensity,
    input  logic                                in_mask,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [vgls_pkg::RESP_W-1:0]  response
);
    import vgls_pkg::*;

    logic [SIZE_W-1:0] sx_reg, sy_reg, sz_reg;
    logic              mode_reg;
    logic [SIZE_W-1:0] ex, ey, ez;
    logic              q_valid, q_take;
    vgls_cmd_t         q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg   <= SIZE_W'(64);
            sy_reg   <= SIZE_W'(64);
            sz_reg   <= SIZE_W'(64);
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: sx_reg   <= cfg_data;
                CFG_SIZE_Y: sy_reg   <= cfg_data;
                CFG_SIZE_Z: sz_reg   <= cfg_data;
                CFG_MODE:   mode_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign ex = (32'(sx_reg) > MAX_X) ? SIZE_W'(MAX_X) : sx_reg;
    assign ey = (32'(sy_reg) > MAX_Y) ? SIZE_W'(MAX_Y) : sy_reg;
    assign ez = (32'(sz_reg) > MAX_Z) ? SIZE_W'(MAX_Z) : sz_reg;

    vgls_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS))
    u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .intensity(intensity), .in_mask(in_mask), .ex(ex), .ey(ey), .ez(ez),
        .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    vgls_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS))
    u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .ex(ex), .ey(ey), .ez(ez), .mode(mode_reg), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .response(response)
    );
endmodule

// ===== tb/sv/vgls_stencil_checker.sv =====
// Checker for the voxel stencil core: watches the configuration port and both channels.
// Predicts each result from its own copy of the volume and registers; depends on vgls_pkg.
`timescale 1ns / 1ps

module vgls_stencil_checker
    import vgls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     operation,
    input  logic [POS_W-1:0]         pos_x,
    input  logic [POS_W-1:0]         pos_y,
    input  logic [POS_W-1:0]         pos_z,
    input  logic [15:0]              intensity,
    input  logic                     in_mask,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [1:0]               status,
    input  logic [RESP_W-1:0]        response,
    output int                       pending,
    output int                       failures
);

    typedef struct packed {
        logic [1:0]        st;
        logic [RESP_W-1:0] resp;
    } outcome_t;

    outcome_t    outcome_q[$];
    logic [16:0] voxel_mem [0:262143];
    logic [6:0]  sz_x, sz_y, sz_z;
    logic        lap_mode;

    assign pending = outcome_q.size();

    initial failures = 0;

    function automatic int eff_size(logic [6:0] s);
        return (s > 7'd64) ? 64 : int'(s);
    endfunction

    function automatic int vox_addr(int x, int y, int z);
        return (z * 64 + y) * 64 + x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint neighbour(int x, int y, int z, int ex, int ey, int ez,
                                         longint c);
        if (x < 0 || y < 0 || z < 0 || x >= ex || y >= ey || z >= ez)
            return c;
        return longint'($signed(voxel_mem[vox_addr(x, y, z)][15:0]));
    endfunction

    function automatic outcome_t stencil_outcome(logic op, int x, int y, int z,
                                                 logic [15:0] val, logic m);
        outcome_t o;
        int ex, ey, ez;
        longint c, w, e, n, s, f, b, dx, dy, dz;
        longint unsigned r;
        ex = eff_size(sz_x);
        ey = eff_size(sz_y);
        ez = eff_size(sz_z);
        o.resp = '0;
        if (!(x < ex && y < ey && z < ez)) begin
            o.st = (op == OP_WRITE) ? ST_WRITE_OOR : ST_SKIPPED;
            return o;
        end
        if (op == OP_WRITE) begin
            voxel_mem[vox_addr(x, y, z)] = {m, val};
            o.st = ST_WRITTEN;
            return o;
        end
        if (!voxel_mem[vox_addr(x, y, z)][16]) begin
            o.st = ST_SKIPPED;
            return o;
        end
        c = longint'($signed(voxel_mem[vox_addr(x, y, z)][15:0]));
        w = neighbour(x - 1, y, z, ex, ey, ez, c);
        e = neighbour(x + 1, y, z, ex, ey, ez, c);
        n = neighbour(x, y - 1, z, ex, ey, ez, c);
        s = neighbour(x, y + 1, z, ex, ey, ez, c);
        f = neighbour(x, y, z - 1, ex, ey, ez, c);
        b = neighbour(x, y, z + 1, ex, ey, ez, c);
        if (!lap_mode) begin
            dx = w - e;
            dy = n - s;
            dz = f - b;
            r = int_sqrt(longint'(dx * dx + dy * dy + dz * dz) * 256);
        end else begin
            r = 6 * c - (w + e + n + s + f + b);
        end
        o.st = ST_COMPUTED;
        o.resp = r[RESP_W-1:0];
        return o;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            sz_x = 7'd64;
            sz_y = 7'd64;
            sz_z = 7'd64;
            lap_mode = 1'b0;
            outcome_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SIZE_X: sz_x = cfg_data;
                    CFG_SIZE_Y: sz_y = cfg_data;
                    CFG_SIZE_Z: sz_z = cfg_data;
                    CFG_MODE:   lap_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                outcome_q.push_back(stencil_outcome(operation, int'(pos_x), int'(pos_y),
                                                    int'(pos_z), intensity, in_mask));
            if (out_valid && !out_stall) begin
                if (outcome_q.size() == 0) begin
                    report("unexpected result, status", int'(status), -1);
                end else begin
                    want = outcome_q.pop_front();
                    if (status !== want.st)
                        report("status", int'(status), int'(want.st));
                    if (response !== want.resp)
                        report("response", int'($signed(response)), int'($signed(want.resp)));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_voxel_gradient_laplacian_stencil_core.sv =====
// Top of the voxel stencil core testbench: clock, reset, stimulus and verdict.
// Depends on vgls_pkg, the core and vgls_stencil_checker.
`timescale 1ns / 1ps

module tb_voxel_gradient_laplacian_stencil_core;
    import vgls_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              operation = OP_WRITE;
    logic [POS_W-1:0]  pos_x = '0;
    logic [POS_W-1:0]  pos_y = '0;
    logic [POS_W-1:0]  pos_z = '0;
    logic [15:0]       intensity = '0;
    logic              in_mask = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [RESP_W-1:0] response;
    int                pending;
    int                failures;

    bit   written [0:262143];
    int   eff_x, eff_y, eff_z;
    bit   quiet = 0;
    bit   hold_req = 0;
    int   idle_cycles = 0;

    voxel_gradient_laplacian_stencil_core dut (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .operation, .pos_x, .pos_y, .pos_z,
        .intensity, .in_mask, .out_valid, .out_stall, .status, .response
    );

    vgls_stencil_checker u_checker (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .operation, .pos_x, .pos_y, .pos_z,
        .intensity, .in_mask, .out_valid, .out_stall, .status, .response,
        .pending, .failures
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_voxel_gradient_laplacian_stencil_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 0;
            end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_voxel(logic op, int x, int y, int z, logic [15:0] val, logic m);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        pos_x     <= POS_W'(x);
        pos_y     <= POS_W'(y);
        pos_z     <= POS_W'(z);
        intensity <= val;
        in_mask   <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_WRITE && x < eff_x && y < eff_y && z < eff_z)
            written[(z * 64 + y) * 64 + x] = 1;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
    endtask

    task automatic set_config(int sx, int sy, int sz, int mode);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        write_reg(CFG_MODE, mode);
        cfg_we <= 1'b0;
        eff_x = (sx > 64) ? 64 : sx;
        eff_y = (sy > 64) ? 64 : sy;
        eff_z = (sz > 64) ? 64 : sz;
    endtask

    task automatic fill_volume();
        for (int z = 0; z < eff_z; z++)
            for (int y = 0; y < eff_y; y++)
                for (int x = 0; x < eff_x; x++)
                    if (!written[(z * 64 + y) * 64 + x])
                        send_voxel(OP_WRITE, x, y, z, 16'($urandom),
                                   $urandom_range(0, 3) != 0);
    endtask

    task automatic random_voxels(int count);
        int  r, x, y, z;
        logic op;
        for (int i = 0; i < count; i++) begin
            r  = $urandom_range(0, 99);
            op = (r >= 45) ? OP_QUERY : OP_WRITE;
            if ((r % 45) < 38 && eff_x > 0 && eff_y > 0 && eff_z > 0) begin
                x = $urandom_range(0, eff_x - 1);
                y = $urandom_range(0, eff_y - 1);
                z = $urandom_range(0, eff_z - 1);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
                z = $urandom_range(0, 63);
            end
            send_voxel(op, x, y, z, 16'($urandom), $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_config(3, 3, 3, 0);
        fill_volume();
        send_voxel(OP_WRITE, 1, 1, 1, 16'h7FFF, 1'b1);
        send_voxel(OP_WRITE, 0, 1, 1, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 2, 1, 1, 16'h7FFF, 1'b0);
        send_voxel(OP_WRITE, 1, 0, 1, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 1, 2, 1, 16'h7FFF, 1'b0);
        send_voxel(OP_WRITE, 1, 1, 0, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 1, 1, 2, 16'h7FFF, 1'b0);
        send_voxel(OP_QUERY, 1, 1, 1, 16'h0000, 1'b0);
        send_voxel(OP_WRITE, 0, 0, 0, 16'h1234, 1'b0);
        send_voxel(OP_QUERY, 0, 0, 0, 16'hFFFF, 1'b1);
        send_voxel(OP_WRITE, 2, 2, 2, 16'h8000, 1'b1);
        send_voxel(OP_QUERY, 2, 2, 2, 16'h0000, 1'b0);
        send_voxel(OP_WRITE, 3, 0, 0, 16'h0001, 1'b1);
        send_voxel(OP_WRITE, 63, 63, 63, 16'hFFFF, 1'b1);
        send_voxel(OP_QUERY, 63, 63, 63, 16'h0000, 1'b0);
        send_voxel(OP_QUERY, 0, 3, 0, 16'h0000, 1'b0);
        set_config(3, 3, 3, 1);
        send_voxel(OP_WRITE, 0, 1, 1, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 2, 1, 1, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 1, 2, 1, 16'h8000, 1'b0);
        send_voxel(OP_WRITE, 1, 1, 2, 16'h8000, 1'b0);
        send_voxel(OP_QUERY, 1, 1, 1, 16'h0000, 1'b0);
        send_voxel(OP_QUERY, 2, 2, 2, 16'h0000, 1'b0);
        random_voxels(130);

        set_config(1, 1, 1, 0);
        random_voxels(100);
        set_config(127, 1, 1, 1);
        fill_volume();
        random_voxels(150);
        set_config(1, 64, 1, 0);
        fill_volume();
        hold_req = 1;
        random_voxels(150);
        set_config(1, 1, 64, 1);
        fill_volume();
        random_voxels(150);
        set_config(0, 5, 5, 0);
        random_voxels(80);
        set_config(4, 5, 3, 1);
        fill_volume();
        random_voxels(170);
        set_config(5, 4, 4, 0);
        fill_volume();
        random_voxels(170);
        quiet = 1;
        set_config(2, 2, 2, 1);
        fill_volume();
        random_voxels(450);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (failures == 0)
            $display("tb_voxel_gradient_laplacian_stencil_core OK");
        else
            $display("tb_voxel_gradient_laplacian_stencil_core NOT OK");
        $finish;
    end

endmodule
